// File: design/hcs_pkg.sv
`timescale 1ns / 1ps
package hcs_pkg;
    localparam int COUNT_BITS_DEF = 22;
    localparam int THRESH_BITS    = 22;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 22'd50;
    localparam int LEVELS    = 256;
    localparam int PIX_BITS  = 8;
    localparam logic [0:0] MODE_COUNT = 1'b0;
    localparam logic [0:0] MODE_MAP   = 1'b1;
    localparam logic [0:0] ADDR_THRESH = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_SCAN_LO,
        ST_SCAN_HI,
        ST_DIV,
        ST_BUILD,
        ST_MAP_RD,
        ST_MAP_OUT
    } t_state;

    // divider request and status between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [17:0] num;
        logic [9:0]  den;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quo;
    } t_div_rsp;
endpackage

// File: design/hcs_div.sv
`timescale 1ns / 1ps
module hcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcs_pkg::t_div_req i_req,
    output hcs_pkg::t_div_rsp o_rsp
);
    import hcs_pkg::*;

    // restoring divider, one quotient bit a cycle; quotient fits 8 bits
    logic [17:0] r_rem, n_rem;
    logic [9:0]  r_den;
    logic [7:0]  r_quo, n_quo;
    logic [3:0]  r_cnt;
    logic        r_busy, r_done;
    logic [18:0] w_trial;

    always_comb begin
        w_trial = {1'b0, r_rem} - ({9'd0, r_den} << r_cnt[2:0]);
        n_rem = r_rem;
        n_quo = r_quo;
        if (!w_trial[18]) begin
            n_rem = w_trial[17:0];
            n_quo[r_cnt[2:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd7;
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
                r_quo  <= 8'd0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 4'd7) else $error("divider count out of range");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> {8'd0, r_den} > r_rem) else $error("divider remainder too big");
endmodule

// File: design/histogram_contrast_stretch.sv
`timescale 1ns / 1ps
// count request: busy through a read state and a write state, then idle for the next request
// map request with table built: a table read state, then the result strobe, then idle
// first map after counting: a low-bound scan and a high-bound scan over the bins, then
// the table build, one level at a time, each level inside the bounds waiting on the shared divider
// first request after reset or first count after mapping clears the histogram first
// synchronous active-low reset: threshold back to 50, counting phase; no receiver stall
module histogram_contrast_stretch #(
    parameter int COUNT_BITS = hcs_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    output logic [7:0]  o_mapped_pixel,
    output logic        o_bounds_found,
    output logic [7:0]  o_low_level,
    output logic [7:0]  o_high_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hcs_pkg::*;

    localparam logic [COUNT_BITS-1:0] BIN_MAX = '1;

    // histogram and table memories
    logic [COUNT_BITS-1:0] r_bins [LEVELS];
    logic [7:0]            r_tab  [LEVELS];

    t_state      r_state, n_state;
    logic [THRESH_BITS-1:0] r_thresh;
    logic        r_phase, r_clean;
    logic [7:0]  r_lo, r_hi;
    logic        r_found;
    logic [7:0]  r_pix;
    logic [8:0]  r_idx;
    logic        r_mode;
    logic [COUNT_BITS-1:0] r_bin_rd;
    logic [7:0]  r_tab_rd;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;
    logic        w_over;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[1:1] == ADDR_THRESH) ? {{(32-THRESH_BITS){1'b0}}, r_thresh} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && paddr[1:1] == ADDR_THRESH
                     && paddr[0] == 1'b0) begin
            r_thresh <= pwdata[THRESH_BITS-1:0];
        end
    end

    // bin compare against threshold, widths aligned
    always_comb begin
        if (COUNT_BITS >= THRESH_BITS)
            w_over = 64'(r_bin_rd) > 64'(r_thresh);
        else
            w_over = 64'(r_bin_rd) > 64'(r_thresh);
    end

    logic [7:0] w_off;
    assign w_off = r_idx[7:0] - r_lo;

    // sequencer
    always_comb begin
        n_state = r_state;
        w_div_req.start = 1'b0;
        w_div_req.num   = 18'(w_off) * 18'd510;
        w_div_req.den   = {1'b0, (r_hi - r_lo), 1'b1};
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_COUNT)
                        n_state = (r_phase || !r_clean) ? ST_CLR : ST_CNT_RD;
                    else
                        n_state = r_phase ? ST_MAP_RD : (r_clean ? ST_SCAN_LO : ST_CLR);
                end
            end
            ST_CLR:     if (r_idx == 9'd255) n_state = r_mode ? ST_SCAN_LO : ST_CNT_RD;
            ST_CNT_RD:  n_state = ST_CNT_WR;
            ST_CNT_WR:  n_state = ST_IDLE;
            ST_SCAN_LO: if (r_idx == 9'd257) n_state = ST_SCAN_HI;
            ST_SCAN_HI: if (r_idx == 9'd257) n_state = ST_BUILD;
            ST_BUILD: begin
                if (r_idx == 9'd256) n_state = ST_MAP_RD;
                else if (r_found && r_idx[7:0] >= r_lo && r_idx[7:0] <= r_hi) begin
                    w_div_req.start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV:     if (w_div_rsp.done) n_state = ST_BUILD;
            ST_MAP_RD:  n_state = ST_MAP_OUT;
            ST_MAP_OUT: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_clean <= 1'b0;
            r_found <= 1'b0;
            r_lo    <= 8'd0;
            r_hi    <= 8'd0;
            r_idx   <= 9'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_idx  <= 9'd0;
                    r_pix  <= i_pixel;
                    r_mode <= i_mode;
                    if (i_start && i_mode == MODE_MAP && !r_phase) begin
                        r_found <= 1'b0;
                        r_lo    <= 8'd0;
                        r_hi    <= 8'd0;
                    end
                end
                ST_CLR: begin
                    r_bins[r_idx[7:0]] <= '0;
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'd255) begin
                        r_clean <= 1'b1;
                        r_phase <= 1'b0;
                        r_idx   <= 9'd0;
                    end
                end
                ST_CNT_RD: r_bin_rd <= r_bins[r_pix];
                ST_CNT_WR: if (r_bin_rd != BIN_MAX) r_bins[r_pix] <= r_bin_rd + 1'b1;
                ST_SCAN_LO: begin
                    // bin data is registered, so each compare checks the bin of the index before r_idx
                    r_bin_rd <= r_bins[r_idx[7:0]];
                    if (r_idx != 9'd0 && w_over && !r_found) begin
                        r_found <= 1'b1;
                        r_lo    <= r_idx[7:0] - 8'd1;
                    end
                    r_idx <= (r_idx == 9'd257) ? 9'd0 : r_idx + 9'd1;
                end
                ST_SCAN_HI: begin
                    // last compare is bin 255, the wrapped read after it is ignored
                    if (r_idx != 9'd0 && r_idx != 9'd257 && w_over)
                        r_hi <= r_idx[7:0] - 8'd1;
                    r_bin_rd <= r_bins[r_idx[7:0]];
                    r_idx <= (r_idx == 9'd257) ? 9'd0 : r_idx + 9'd1;
                end
                ST_BUILD: begin
                    r_phase <= 1'b1;
                    if (r_idx != 9'd256 && !(r_found && r_idx[7:0] >= r_lo
                                             && r_idx[7:0] <= r_hi)) begin
                        r_tab[r_idx[7:0]] <= (r_found && r_idx[7:0] > r_hi) ? 8'd255 : 8'd0;
                        r_idx <= r_idx + 9'd1;
                    end
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_tab[r_idx[7:0]] <= w_div_rsp.quo;
                        r_idx <= r_idx + 9'd1;
                    end
                end
                ST_MAP_RD: r_tab_rd <= r_tab[r_pix];
                default: ;
            endcase
        end
    end

    hcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_MAP_OUT);
    assign o_mapped_pixel = r_tab_rd;
    assign o_bounds_found = r_found;
    assign o_low_level    = r_lo;
    assign o_high_level   = r_hi;

    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held over two cycles");
    a_map_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_phase) else $error("result without built table");
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_found |-> r_lo <= r_hi) else $error("bounds out of order");
endmodule
